/* sv/fpq16_pkg.sv */
package fpq16_pkg;

	// Word format: signed fixed point with FRAC_BITS fraction bits.
	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// The divider works on the magnitude of the dividend shifted left by the
	// fraction width. It handles DIV_STEPS quotient bits per pipeline stage.
	// The dividend is padded with leading zeros so that it fills a whole
	// number of stages.
	localparam int DVD_BITS   = WORD_BITS + FRAC_BITS;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (DVD_BITS + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DVD_PAD    = DIV_STAGES * DIV_STEPS;

	typedef enum logic [1:0] {
		MODE_ADD = 2'd0,
		MODE_SUB = 2'd1,
		MODE_MUL = 2'd2,
		MODE_DIV = 2'd3
	} mode_t;

	typedef struct packed {
		mode_t                        mode;
		logic signed [WORD_BITS-1:0]  operand_a;
		logic signed [WORD_BITS-1:0]  operand_b;
	} req_t;

	typedef struct packed {
		logic signed [WORD_BITS-1:0]  result;
		logic                         divide_by_zero;
	} res_t;

	// State that travels down the divider pipeline with each request.
	typedef struct packed {
		mode_t                   mode;
		logic                    neg;
		logic                    dz;
		logic [WORD_BITS-1:0]    mb;
		logic [WORD_BITS:0]      rem;
		logic [DVD_PAD-1:0]      dvd;
		logic [WORD_BITS-1:0]    quo;
		logic [WORD_BITS-1:0]    other;
	} div_t;

endpackage

/* sv/fpq16_div_stage.sv */
module fpq16_div_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  fpq16_pkg::div_t   din,
	output logic              out_valid,
	output fpq16_pkg::div_t   dout
);

	fpq16_pkg::div_t nxt;
	logic            valid_q;
	fpq16_pkg::div_t data_q;

	// Several restoring division steps: shift in one dividend bit, then
	// subtract the divisor if the partial remainder is large enough.
	always_comb begin
		logic [fpq16_pkg::WORD_BITS:0] r;
		nxt = din;
		r   = '0;
		for (int i = 0; i < fpq16_pkg::DIV_STEPS; i++) begin
			r = {nxt.rem[fpq16_pkg::WORD_BITS-1:0], nxt.dvd[fpq16_pkg::DVD_PAD-1]};
			nxt.dvd = nxt.dvd << 1;
			if (r >= {1'b0, nxt.mb}) begin
				nxt.rem = r - {1'b0, nxt.mb};
				nxt.quo = {nxt.quo[fpq16_pkg::WORD_BITS-2:0], 1'b1};
			end else begin
				nxt.rem = r;
				nxt.quo = {nxt.quo[fpq16_pkg::WORD_BITS-2:0], 1'b0};
			end
		end
	end

	// The valid bit is cleared by reset; the payload needs none.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign dout      = data_q;

endmodule

/* sv/fixed_point_q16_alu.sv */
// Signed Q16.16 fixed-point arithmetic unit.
// A request on req (mode, operand_a, operand_b) is taken at a rising edge
// where req_valid is high and req_stall is low. Modes: add, subtract,
// multiply (product shifted right by the fraction width) and divide
// (dividend shifted left by the fraction width, truncated toward zero).
// All results wrap to the word. A zero divisor gives result 0 with
// divide_by_zero set.
// Every request gives exactly one response on res, in request order, taken
// when res_valid is high and res_stall is low.
// The input register loads at the edge that takes the request, then comes
// one stage per four quotient bits of the restoring divider, then the output
// register. All modes share that pipeline, so one request is taken every
// cycle while req_stall is low. The divider stages set the depth.
// When the receiver stalls with a response waiting, the whole pipeline
// holds and req_stall rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the unit then accepts at once.
module fixed_point_q16_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  fpq16_pkg::req_t   req,
	output logic              res_valid,
	input  logic              res_stall,
	output fpq16_pkg::res_t   res
);

	localparam int W = fpq16_pkg::WORD_BITS;
	localparam int F = fpq16_pkg::FRAC_BITS;
	localparam int N = fpq16_pkg::DIV_STAGES;

	logic adv;

	logic            v_s1;
	fpq16_pkg::div_t st_s1;
	logic [W-1:0]    a_s1;
	logic [W-1:0]    b_s1;
	fpq16_pkg::div_t st_d;

	logic            vchain [0:N];
	fpq16_pkg::div_t chain  [0:N];

	logic signed [2*W-1:0] prod;
	fpq16_pkg::res_t       res_d;
	fpq16_pkg::res_t       res_q;
	logic                  res_valid_q;

	// The pipeline moves unless a finished response is held.
	assign adv       = !res_valid_q || !res_stall;
	assign req_stall = !adv;

	// Input stage: magnitudes, sign and zero-divisor check, add and subtract.
	always_comb begin
		st_d       = '0;
		st_d.mode  = req.mode;
		st_d.neg   = req.operand_a[W-1] ^ req.operand_b[W-1];
		st_d.dz    = (req.operand_b == '0);
		st_d.mb    = req.operand_b[W-1] ? (W)'(-req.operand_b) : req.operand_b;
		st_d.dvd   = (fpq16_pkg::DVD_PAD)'({req.operand_a[W-1] ? (W)'(-req.operand_a)
			: req.operand_a, {F{1'b0}}});
		case (req.mode)
			fpq16_pkg::MODE_ADD: st_d.other = req.operand_a + req.operand_b;
			fpq16_pkg::MODE_SUB: st_d.other = req.operand_a - req.operand_b;
			default:             st_d.other = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			st_s1 <= st_d;
			a_s1  <= req.operand_a;
			b_s1  <= req.operand_b;
		end
	end

	// Multiply beside the first divider stage; the product is registered there.
	assign prod = $signed(a_s1) * $signed(b_s1);

	always_comb begin
		chain[0] = st_s1;
		if (st_s1.mode == fpq16_pkg::MODE_MUL) begin
			chain[0].other = prod[F+W-1:F];
		end
	end
	assign vchain[0] = v_s1;

	// Divider pipeline.
	for (genvar g = 0; g < N; g++) begin : g_div
		fpq16_div_stage u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.in_valid (vchain[g]),
			.din      (chain[g]),
			.out_valid(vchain[g+1]),
			.dout     (chain[g+1])
		);
	end

	// Final selection: signed quotient or the carried result.
	always_comb begin
		res_d = '0;
		if (chain[N].mode == fpq16_pkg::MODE_DIV) begin
			if (chain[N].dz) begin
				res_d.divide_by_zero = 1'b1;
			end else begin
				res_d.result = chain[N].neg ? (W)'(-chain[N].quo) : chain[N].quo;
			end
		end else begin
			res_d.result = chain[N].other;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= vchain[N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* sv/fpq16_chk.sv */
module fpq16_chk (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_stall,
	input  fpq16_pkg::req_t   req,
	input  logic              res_valid,
	input  logic              res_stall,
	input  fpq16_pkg::res_t   res
);

	// A held response stays valid.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid)
		else $error("response dropped while stalled");

	// The unit stalls requests exactly while a response is held.
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall == (res_valid && res_stall))
		else $error("request stall does not follow response stall");

	// A zero-divisor response carries a zero result.
	a_dz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.divide_by_zero |-> res.result == '0)
		else $error("divide by zero with nonzero result");

	// No response in the cycle after reset releases.
	a_reset_empty: assert property (@(posedge clk)
		$rose(arst_n) |-> !res_valid)
		else $error("response valid right after reset");

endmodule

bind fixed_point_q16_alu fpq16_chk u_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.req_valid(req_valid),
	.req_stall(req_stall),
	.req      (req),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

/* dv/fixed_point_q16_alu_tb.sv */
module fixed_point_q16_alu_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_RANDOM    = 1750;
	localparam int IDLE_LIMIT  = 20000;
	localparam int DRAIN_TICKS = 40;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	fpq16_pkg::req_t req;
	logic res_valid;
	logic res_stall;
	fpq16_pkg::res_t res;

	fpq16_pkg::req_t pending_reqs[$];
	fpq16_pkg::res_t expected_results[$];
	int   error_count;
	int   requests_sent;
	int   results_checked;
	int   idle_cycles;
	int   cycle_count;
	int   total_reqs;
	bit   req_fire;
	int   mode_hits[4];
	int   dz_hits;

	fixed_point_q16_alu u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	// Clock with a 12 ns period.
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Computes the Q16.16 result of one request.
	function automatic fpq16_pkg::res_t alu_compute(fpq16_pkg::req_t r);
		logic signed [63:0]  a;
		logic signed [63:0]  b;
		logic signed [127:0] prod;
		logic signed [127:0] quo;
		fpq16_pkg::res_t o;
		a = r.operand_a;
		b = r.operand_b;
		o.divide_by_zero = 1'b0;
		o.result = '0;
		case (r.mode)
			fpq16_pkg::MODE_ADD: o.result = 32'(a + b);
			fpq16_pkg::MODE_SUB: o.result = 32'(a - b);
			fpq16_pkg::MODE_MUL: begin
				prod = 128'(a) * 128'(b);
				o.result = 32'(prod >>> fpq16_pkg::FRAC_BITS);
			end
			default: begin
				if (b == 0) begin
					o.divide_by_zero = 1'b1;
				end else begin
					// Signed division truncates toward zero.
					quo = (128'(a) <<< fpq16_pkg::FRAC_BITS) / 128'(b);
					o.result = 32'(quo);
				end
			end
		endcase
		return o;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(signed'($urandom_range(0, 8)) - 4);
			3: return 32'(signed'($urandom_range(0, 16)) - 8) << 16;
			4: return 32'($urandom_range(0, 65535)) - 32'd32768;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_request(fpq16_pkg::mode_t m, logic [31:0] a, logic [31:0] b);
		fpq16_pkg::req_t r;
		r.mode = m;
		r.operand_a = a;
		r.operand_b = b;
		pending_reqs.push_back(r);
	endtask

	// Driver: presents the next request at the falling edge, holds it until taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!req_valid || req_fire) begin
				if (pending_reqs.size() > 0 &&
					((cycle_count % 1000) < 300 || $urandom_range(0, 99) >= 6)) begin
					req <= pending_reqs.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
			res_stall <= ((cycle_count % 1000) >= 300) && ($urandom_range(0, 99) < 6);
		end
	end

	// Monitor: predicts on accepted requests and checks accepted results.
	always @(posedge clk) begin
		fpq16_pkg::res_t e;
		bit res_fire;
		req_fire = arst_n && req_valid && !req_stall;
		res_fire = arst_n && res_valid && !res_stall;
		if (arst_n) begin
			cycle_count <= cycle_count + 1;
			if (req_fire || res_fire) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (req_fire) begin
				expected_results.push_back(alu_compute(req));
				mode_hits[req.mode]++;
				if (req.mode == fpq16_pkg::MODE_DIV && req.operand_b == 0) dz_hits++;
				requests_sent++;
			end
			if (res_fire) begin
				results_checked++;
				if (expected_results.size() == 0) begin
					$display("%0t: result expected none actual %h", $time, res);
					error_count++;
				end else begin
					e = expected_results.pop_front();
					if (res.result !== e.result) begin
						$display("%0t: result expected %h actual %h",
							$time, e.result, res.result);
						error_count++;
					end
					if (res.divide_by_zero !== e.divide_by_zero) begin
						$display("%0t: divide_by_zero expected %b actual %b",
							$time, e.divide_by_zero, res.divide_by_zero);
						error_count++;
					end
				end
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Watchdog expired after %0d idle cycles.", idle_cycles);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	initial begin
		error_count = 0;
		requests_sent = 0;
		results_checked = 0;
		idle_cycles = 0;
		cycle_count = 0;
		dz_hits = 0;
		req_fire = 1'b0;
		for (int i = 0; i < 4; i++) mode_hits[i] = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		res_stall = 1'b0;
		req = '0;

		// Directed requests: extremes, every mode, zero divisor, wrap cases.
		add_request(fpq16_pkg::MODE_ADD, 32'h7fff_ffff, 32'h0000_0001);
		add_request(fpq16_pkg::MODE_ADD, 32'h8000_0000, 32'hffff_ffff);
		add_request(fpq16_pkg::MODE_SUB, 32'h8000_0000, 32'h0000_0001);
		add_request(fpq16_pkg::MODE_SUB, 32'h7fff_ffff, 32'h8000_0000);
		add_request(fpq16_pkg::MODE_MUL, 32'h0001_0000, 32'hffff_0000);
		add_request(fpq16_pkg::MODE_MUL, 32'h8000_0000, 32'h8000_0000);
		add_request(fpq16_pkg::MODE_MUL, 32'h7fff_ffff, 32'h7fff_ffff);
		add_request(fpq16_pkg::MODE_MUL, 32'hffff_ffff, 32'h0000_0001);
		add_request(fpq16_pkg::MODE_MUL, 32'h0000_0000, 32'h8000_0000);
		add_request(fpq16_pkg::MODE_DIV, 32'h0003_0000, 32'h0000_0000);
		add_request(fpq16_pkg::MODE_DIV, 32'h8000_0000, 32'h0000_0000);
		add_request(fpq16_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_0000);
		add_request(fpq16_pkg::MODE_DIV, 32'h8000_0000, 32'hffff_ffff);
		add_request(fpq16_pkg::MODE_DIV, 32'h7fff_ffff, 32'h0000_0001);
		add_request(fpq16_pkg::MODE_DIV, 32'hfffd_0000, 32'h0002_0000);
		add_request(fpq16_pkg::MODE_DIV, 32'h0000_0001, 32'h8000_0000);
		add_request(fpq16_pkg::MODE_DIV, 32'h0007_0000, 32'hfffe_0000);
		add_request(fpq16_pkg::MODE_DIV, 32'h7fff_ffff, 32'h7fff_ffff);
		add_request(fpq16_pkg::MODE_ADD, 32'hffff_ffff, 32'hffff_ffff);
		add_request(fpq16_pkg::MODE_SUB, 32'h0000_0000, 32'h0000_0000);

		// Random requests; about one divide in eight has a zero divisor.
		for (int i = 0; i < N_RANDOM; i++) begin
			fpq16_pkg::mode_t m;
			logic [31:0] b;
			m = fpq16_pkg::mode_t'($urandom_range(0, 3));
			b = rand_operand();
			if (m == fpq16_pkg::MODE_DIV && $urandom_range(0, 7) == 0) b = '0;
			add_request(m, rand_operand(), b);
		end
		total_reqs = pending_reqs.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Wait until every request is taken and every response checked.
		wait (requests_sent == total_reqs && expected_results.size() == 0);
		repeat (DRAIN_TICKS) @(posedge clk);

		$display("Covered %0d requests: add %0d, sub %0d, mul %0d, div %0d.",
			requests_sent, mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3]);
		$display("Checked %0d results, %0d zero-divisor cases, %0d mismatches.",
			results_checked, dz_hits, error_count);
		if (error_count == 0 && expected_results.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
